>>> hdl/pfts_pkg.sv
package pfts_pkg;

    // Default geometry
    localparam int FLOOR_ROWS_DEF   = 127;
    localparam int SCREEN_WIDTH_DEF = 320;
    localparam int TEX_SIZE_DEF     = 64;

    // Item kinds carried on tuser
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_BUILD  = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    // Configuration register indexes
    localparam logic REG_SKY = 1'b0;
    localparam logic REG_DIM = 1'b1;

    // Half of camera height in 16.16: zs = DEPTH_NUM / (row + 6)
    localparam logic [21:0] DEPTH_NUM  = 22'd3145728;
    localparam logic [19:0] FAR_LIMIT  = 20'd98304;
    localparam logic [7:0]  DEPTH_GAIN = 8'd132;
    localparam logic [10:0] HALF_SPAN  = 11'd160;
    localparam logic [6:0]  FOG_ROWS   = 7'd34;
    localparam logic [8:0]  DIM_FULL   = 9'd256;
    localparam int          QDEPTH     = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] texel_address;
        logic [15:0] texel_value;
        logic [6:0]  floor_row;
        logic [8:0]  screen_column;
        logic [21:0] scroll_offset;
    } cmd_t;

    function automatic logic [15:0] swap16(input logic [15:0] c);
        swap16 = {c[7:0], c[15:8]};
    endfunction

endpackage

>>> hdl/pfts_front.sv
module pfts_front
    import pfts_pkg::*;
#(
    parameter int FLOOR_ROWS   = FLOOR_ROWS_DEF,
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
)
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // texel_address, texel_value, floor_row, screen_column, scroll_offset, zero fill
    input  logic [71:0] s_axis_tdata,
    // kind
    input  logic [1:0]  s_axis_tuser,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_data
);

    logic keep;

    // Unpack the item
    always_comb
    begin
        q_data.kind          = s_axis_tuser;
        q_data.texel_address = s_axis_tdata[11:0];
        q_data.texel_value   = s_axis_tdata[27:12];
        q_data.floor_row     = s_axis_tdata[34:28];
        q_data.screen_column = s_axis_tdata[43:35];
        q_data.scroll_offset = s_axis_tdata[65:44];
    end

    // Drop unknown kinds and renders outside the floor area
    always_comb
    begin
        unique case (s_axis_tuser)
            KIND_WRITE, KIND_BUILD: keep = 1'b1;
            KIND_RENDER:
                keep = ({3'b0, q_data.floor_row} < 10'(FLOOR_ROWS)) &&
                       ({2'b0, q_data.screen_column} < 11'(SCREEN_WIDTH));
            default: keep = 1'b0;
        endcase
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full && keep;

endmodule

>>> hdl/pfts_queue.sv
module pfts_queue
    import pfts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    localparam int PW = $clog2(QDEPTH);

    cmd_t            entry_reg [QDEPTH];
    logic [PW-1:0]   wr_reg;
    logic [PW-1:0]   rd_reg;
    logic [PW:0]     cnt_reg;

    assign full     = (cnt_reg == (PW+1)'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = entry_reg[rd_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/pfts_div.sv
module pfts_div
    import pfts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [19:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  dvs_reg;
    logic [21:0] q_reg;
    logic [9:0]  trial;
    logic        fits;

    // One quotient bit per cycle, restoring
    assign trial = {rem_reg, DEPTH_NUM[cnt_reg]};
    assign fits  = (trial >= {2'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd21;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 9'(trial - {2'b0, dvs_reg}) : trial[8:0];
            q_reg   <= {q_reg[20:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[19:0];

endmodule

>>> hdl/pfts_back.sv
module pfts_back
    import pfts_pkg::*;
#(
    parameter int TEX_SIZE = TEX_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        q_empty,
    input  cmd_t        q_data,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata
);

    localparam int TEX_LOG   = $clog2(TEX_SIZE);
    localparam int MIP_LOG   = TEX_LOG - 2;
    localparam int TEX_AW    = 2 * TEX_LOG;
    localparam int MIP_AW    = 2 * MIP_LOG;
    localparam int TEX_DEPTH = TEX_SIZE * TEX_SIZE;
    localparam int MIP_DEPTH = (TEX_SIZE / 4) * (TEX_SIZE / 4);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_ADDR   = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;
    localparam logic [2:0] S_BUILD  = 3'd6;
    localparam logic [2:0] S_BDRAIN = 3'd7;

    function automatic logic [5:0] blend(input logic [5:0] ch, input logic [5:0] sky,
                                         input logic [7:0] fog);
        logic signed [6:0]  delta;
        logic signed [15:0] prod;
        logic signed [15:0] sum;
        delta = $signed({1'b0, sky}) - $signed({1'b0, ch});
        prod  = 16'(delta * $signed({1'b0, fog}));
        sum   = $signed({10'b0, ch}) + (prod >>> 8);
        blend = sum[5:0];
    endfunction

    logic [2:0]         state_reg, state_next;
    cmd_t               cmd_reg;
    logic [15:0]        sky_reg;
    logic [8:0]         dim_reg;
    logic [15:0]        tex_mem [TEX_DEPTH];
    logic [15:0]        mip_mem [MIP_DEPTH];
    logic [15:0]        tex_q_reg;
    logic [15:0]        mip_q_reg;
    logic [TEX_AW-1:0]  tex_raddr;
    logic [MIP_AW-1:0]  mip_raddr;
    logic               tex_we;
    logic               mip_we;
    logic [15:0]        mip_wdata;
    logic               div_start;
    logic               div_done;
    logic [19:0]        div_q;
    logic [19:0]        zs_reg;
    logic               far_reg;
    logic [27:0]        dprod_reg;
    logic signed [31:0] uprod_reg;
    logic [28:0]        vsum;
    logic [TEX_AW-1:0]  bcnt_reg;
    logic               bv_reg;
    logic [3:0]         bsub_reg;
    logic [MIP_AW-1:0]  bidx_reg;
    logic [8:0]         acc_r_reg, acc_r_next;
    logic [9:0]         acc_g_reg, acc_g_next;
    logic [8:0]         acc_b_reg, acc_b_next;
    logic [15:0]        bc;
    logic [15:0]        rc;
    logic [7:0]         fog;
    logic [8:0]         fog15;
    logic [5:0]         br_reg, bg_reg, bb_reg;
    logic [8:0]         dim_eff;
    logic [14:0]        dr, dg, db;
    logic               out_free;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sky_reg <= '0;
            dim_reg <= DIM_FULL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SKY: sky_reg <= cfg_wdata;
                REG_DIM: dim_reg <= cfg_wdata[8:0];
                default: sky_reg <= sky_reg;
            endcase
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign tex_we    = q_pop && (q_data.kind == KIND_WRITE);
    assign div_start = q_pop && (q_data.kind == KIND_RENDER);
    assign out_free  = !out_valid_reg || m_axis_tready;

    pfts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  ({1'b0, q_data.floor_row} + 8'd6),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequence one command at a time
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop && (q_data.kind == KIND_BUILD))
                begin
                    state_next = S_BUILD;
                end
                else if (div_start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:    state_next = div_done ? S_MUL : S_DIV;
            S_MUL:    state_next = S_ADDR;
            S_ADDR:   state_next = S_READ;
            S_READ:   state_next = S_OUT;
            S_OUT:    state_next = out_free ? S_IDLE : S_OUT;
            S_BUILD:  state_next = (bcnt_reg == '1) ? S_BDRAIN : S_BUILD;
            S_BDRAIN: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bcnt_reg  <= '0;
            bv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bv_reg    <= (state_reg == S_BUILD);
            if (state_reg == S_BUILD)
            begin
                bcnt_reg <= bcnt_reg + 1'b1;
            end
        end
    end

    // Render datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (div_done)
        begin
            zs_reg  <= div_q;
            far_reg <= (div_q > FAR_LIMIT);
        end
        if (state_reg == S_MUL)
        begin
            dprod_reg <= zs_reg * DEPTH_GAIN;
            uprod_reg <= 32'($signed({2'b0, cmd_reg.screen_column} - HALF_SPAN) *
                             $signed({1'b0, zs_reg}));
        end
        if (state_reg == S_READ)
        begin
            br_reg <= blend({1'b0, rc[15:11]}, {1'b0, sky_reg[15:11]}, fog);
            bg_reg <= blend(rc[10:5], sky_reg[10:5], fog);
            bb_reg <= blend({1'b0, rc[4:0]}, {1'b0, sky_reg[4:0]}, fog);
        end
    end

    // Texel coordinates; near field reads the texture, far field the mip
    assign vsum = {7'b0, cmd_reg.scroll_offset} + {1'b0, dprod_reg};

    always_comb
    begin
        if (state_reg == S_BUILD)
        begin
            tex_raddr = {bcnt_reg[TEX_AW-1:4+MIP_LOG], bcnt_reg[3:2],
                         bcnt_reg[4+MIP_LOG-1:4], bcnt_reg[1:0]};
        end
        else
        begin
            tex_raddr = {vsum[16 +: TEX_LOG], uprod_reg[16 +: TEX_LOG]};
        end
        mip_raddr = {vsum[18 +: MIP_LOG], uprod_reg[18 +: MIP_LOG]};
    end

    // Texture memory
    always_ff @(posedge clk)
    begin
        if (tex_we)
        begin
            tex_mem[q_data.texel_address[TEX_AW-1:0]] <= q_data.texel_value;
        end
        tex_q_reg <= tex_mem[tex_raddr];
    end

    // Box filter accumulation, one texel a cycle
    assign bc         = swap16(tex_q_reg);
    assign acc_r_next = ((bsub_reg == '0) ? 9'd0 : acc_r_reg) + {4'b0, bc[15:11]};
    assign acc_g_next = ((bsub_reg == '0) ? 10'd0 : acc_g_reg) + {4'b0, bc[10:5]};
    assign acc_b_next = ((bsub_reg == '0) ? 9'd0 : acc_b_reg) + {4'b0, bc[4:0]};
    assign mip_we     = bv_reg && (bsub_reg == 4'hF);
    assign mip_wdata  = swap16({acc_r_next[8:4], acc_g_next[9:4], acc_b_next[8:4]});

    always_ff @(posedge clk)
    begin
        bsub_reg <= bcnt_reg[3:0];
        bidx_reg <= bcnt_reg[TEX_AW-1:4];
        if (bv_reg)
        begin
            acc_r_reg <= acc_r_next;
            acc_g_reg <= acc_g_next;
            acc_b_reg <= acc_b_next;
        end
    end

    // Mip memory
    always_ff @(posedge clk)
    begin
        if (mip_we)
        begin
            mip_mem[bidx_reg] <= mip_wdata;
        end
        mip_q_reg <= mip_mem[mip_raddr];
    end

    // Fog weight 255*(34-row)/34 equals 15*(34-row)/2
    assign fog15 = 9'(6'(FOG_ROWS - cmd_reg.floor_row) * 4'd15);
    assign fog   = (cmd_reg.floor_row < FOG_ROWS) ? fog15[8:1] : 8'd0;
    assign rc    = swap16(far_reg ? mip_q_reg : tex_q_reg);

    // Dim scale, saturated at full brightness
    assign dim_eff = (dim_reg > DIM_FULL) ? DIM_FULL : dim_reg;
    assign dr      = br_reg * dim_eff;
    assign dg      = bg_reg * dim_eff;
    assign db      = bb_reg * dim_eff;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_OUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && out_free)
        begin
            out_data_reg <= {cmd_reg.screen_column, cmd_reg.floor_row,
                             swap16({dr[12:8], dg[13:8], db[12:8]})};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside depth wait");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) && out_valid_reg && !m_axis_tready |=> (state_reg == S_OUT))
        else $error("result left while output register was stalled");
    a_mip_build: assert property (@(posedge clk) disable iff (!rst_n)
        mip_we |-> ((state_reg == S_BUILD) || (state_reg == S_BDRAIN)))
        else $error("mip written outside a build");
`endif

endmodule

>>> hdl/perspective_floor_texture_sampler.sv
// Perspective floor texture sampler.
// Input stream s_axis: tuser carries the kind (write texel, build mip, render pixel),
// tdata the texel and render fields. Output stream m_axis returns one pixel per
// render item, in order; writes, builds, unknown kinds and off-screen renders
// give nothing.
// Configuration: cfg_we with cfg_index 0 sets the sky color, index 1 the dim level.
// Write only while the block is idle.
// Items enter a four-deep command queue and are carried out one at a time:
//   texel write: stored in the texture memory as it leaves the queue
//   mip build: one texture read per cycle across the whole texture, then a drain state
//   render: the 22-step depth divider, then multiply, address, texture read and
//   fog blend, dim and output; the next item leaves the queue only once the
//   pixel is loaded into the output register
// The output register frees the back end as soon as the pixel is loaded; while
// m_axis_tready is low one pixel waits there and further items collect in the
// queue until it is full, then s_axis_tready drops.
// Reset clears the queue, output and config (sky 0, dim 256); the texture and
// mip memories hold garbage until written or built.
module perspective_floor_texture_sampler
    import pfts_pkg::*;
#(
    parameter int FLOOR_ROWS   = FLOOR_ROWS_DEF,
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int TEX_SIZE     = TEX_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // texel_address, texel_value, floor_row, screen_column, scroll_offset, zero fill
    input  logic [71:0] s_axis_tdata,
    // kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel, out_row, out_column
    output logic [31:0] m_axis_tdata
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t q_in;
    cmd_t q_out;

    pfts_front #(
        .FLOOR_ROWS   (FLOOR_ROWS),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    pfts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    pfts_back #(
        .TEX_SIZE (TEX_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
